>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: item layouts, action
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Action codes carried in an input item
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_QUERY      = 3'd5
  } action_t;

  // Input item
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               push_dropped;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } deq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } deq_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// Each input item (push front, push back, pop front, pop back, clear, query)
// yields one result with the front and back values, the count and the empty
// flag after the action; front and back read -1 when empty, and a push into a
// full queue is dropped with push_dropped set. An item passes through the
// controller states in order: the capture cycle ending in the transfer, the ring
// update with the memory write, the registered read of both ends, and the
// result register load. The block takes no new item until the previous result
// sits in the output register; a stalled result holds the load step and with it
// the input. No clearing pass is needed after reset.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire deq_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output deq_pkg::out_item_t      out_item
);

  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the queue: capture an item, update the ring, read both ends,
// then load the result register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t      cmd
);

  deq_pkg::state_t state_r;
  deq_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = deq_pkg::ST_EXEC;
      end
      deq_pkg::ST_EXEC: state_nxt = deq_pkg::ST_READ;
      deq_pkg::ST_READ: state_nxt = deq_pkg::ST_LOAD;
      deq_pkg::ST_LOAD: begin
        if (!sts.out_busy) state_nxt = deq_pkg::ST_IDLE;
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      deq_pkg::ST_EXEC: cmd.exec = 1'b1;
      deq_pkg::ST_READ: cmd.read = 1'b1;
      deq_pkg::ST_LOAD: cmd.load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Ring pointers, count, entry memory and result register of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire deq_pkg::in_item_t in_item,
  input  wire deq_pkg::deq_cmd_t cmd,
  output deq_pkg::deq_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output deq_pkg::out_item_t     out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [2:0]         act_r;
  logic [31:0]        val_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  deq_pkg::out_item_t out_r;

  logic [PTR_W-1:0]   head_prev, head_next, tail_prev, tail_next;
  logic               full, empty;
  logic               we;
  logic [PTR_W-1:0]   waddr;
  logic [31:0]        rdata_a, rdata_b;
  logic [CNT_W+4:0]   cnt_ext;

  // Ring neighbors
  assign head_prev = (head_r == '0) ? LAST_PTR : head_r - 1'b1;
  assign head_next = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? LAST_PTR : tail_r - 1'b1;
  assign tail_next = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
  assign full      = (cnt_r == FULL_CNT);
  assign empty     = (cnt_r == '0);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_item.action;
      val_r <= in_item.item_value;
    end
  end

  // Apply the action to pointers, count and memory
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    we       = 1'b0;
    waddr    = tail_r;
    if (cmd.exec) begin
      drop_nxt = 1'b0;
      case (act_r)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            head_nxt = head_prev;
            waddr    = head_prev;
            we       = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            tail_nxt = tail_next;
            waddr    = tail_r;
            we       = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (!empty) begin
            head_nxt = head_next;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (!empty) begin
            tail_nxt = tail_prev;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        deq_pkg::ACT_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  // Pointer, count and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Entry memory; read front and back after the update
  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (val_r),
    .re      (cmd.read),
    .raddr_a (head_r),
    .raddr_b (tail_prev),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Count masked to the 5-bit result field
  assign cnt_ext = {5'b0, cnt_r};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.front_value  <= empty ? '1 : rdata_a;
      out_r.back_value   <= empty ? '1 : rdata_b;
      out_r.entry_count  <= cnt_ext[4:0];
      out_r.is_empty     <= empty;
      out_r.push_dropped <= drop_r;
    end
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

`default_nettype wire

>>> rtl/core/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire deq_pkg::out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.entry_count == 5'd0)))
    else $error("empty flag disagrees with count");

  // Empty queue shows -1 at both ends
  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_empty |->
      (out_item.front_value == -32'sd1) && (out_item.back_value == -32'sd1))
    else $error("empty queue shows stored values");

  // A dropped push only happens on a non-empty queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.push_dropped |-> !out_item.is_empty)
    else $error("push dropped on empty queue");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the double-ended queue against a ring-buffer predictor. Directed
// items cover the empty and full edges, dropped pushes, clear and the unused
// action codes. Random fill and drain runs follow under several idle and stall
// mixes, plus a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = 16;
  // Action codes outside the enum; the block treats them as a query
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  deq_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  deq_pkg::out_item_t out_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int mismatch_count = 0;

  // Predicted queue contents and pointers
  logic signed [31:0] ring_mem [DEPTH];
  int head_pos   = 0;
  int tail_pos   = 0;
  int fill_count = 0;
  deq_pkg::out_item_t expected_results [$];

  double_ended_queue #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one action to the predicted queue and return the status after it
  function automatic deq_pkg::out_item_t apply_deque_op(input deq_pkg::in_item_t item);
    deq_pkg::out_item_t res;
    res = '0;
    case (item.action)
      deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          res.push_dropped = 1'b1;
        end else if (item.action == deq_pkg::ACT_PUSH_FRONT) begin
          head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
          ring_mem[head_pos] = item.item_value;
          fill_count++;
        end else begin
          ring_mem[tail_pos] = item.item_value;
          tail_pos = (tail_pos + 1) % DEPTH;
          fill_count++;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (fill_count != 0) begin
          head_pos = (head_pos + 1) % DEPTH;
          fill_count--;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (fill_count != 0) begin
          tail_pos = (tail_pos == 0) ? DEPTH - 1 : tail_pos - 1;
          fill_count--;
        end
      end
      deq_pkg::ACT_CLEAR: begin
        head_pos   = 0;
        tail_pos   = 0;
        fill_count = 0;
      end
      default: ;
    endcase
    if (fill_count == 0) begin
      res.front_value = '1;
      res.back_value  = '1;
      res.is_empty    = 1'b1;
    end else begin
      res.front_value = ring_mem[head_pos];
      res.back_value  = ring_mem[(tail_pos + DEPTH - 1) % DEPTH];
    end
    res.entry_count = 5'(fill_count);
    return res;
  endfunction

  // Check each result transfer, then predict for each input transfer
  always @(posedge clk) begin : result_check
    deq_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation pending");
        mismatch_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_item.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, out_item.front_value);
          mismatch_count++;
        end
        if (out_item.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value, out_item.back_value);
          mismatch_count++;
        end
        if (out_item.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_item.entry_count);
          mismatch_count++;
        end
        if (out_item.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, out_item.is_empty);
          mismatch_count++;
        end
        if (out_item.push_dropped !== want.push_dropped) begin
          $error("push_dropped: expected %0b, got %0b", want.push_dropped,
                 out_item.push_dropped);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.insert(expected_results.size(), apply_deque_op(in_item));
    end
  end

  // Drive out_ready: hold low while a hold-off is counting, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one item after a random idle gap and hold it until the transfer
  task automatic send_item(input logic [2:0] act, input logic signed [31:0] val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, item_value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back or DRAIN_LIMIT runs out
  task automatic wait_drain();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      cycles++;
    end while (expected_results.size() != 0 && cycles < DRAIN_LIMIT);
  endtask

  // Mostly random values, with the extremes mixed in
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 32'sh7fff_ffff;
    if (roll < 6) return 32'sh8000_0000;
    if (roll < 8) return 32'sd0;
    if (roll < 10) return -32'sd1;
    return $urandom;
  endfunction

  // Pops, queries and unused codes on an empty queue
  task automatic test_empty_ends();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(deq_pkg::ACT_QUERY, pick_value());
    send_item(deq_pkg::ACT_POP_FRONT, pick_value());
    send_item(deq_pkg::ACT_POP_BACK, pick_value());
    send_item(ACT_RSVD_6, pick_value());
    send_item(ACT_RSVD_7, pick_value());
    send_item(deq_pkg::ACT_CLEAR, pick_value());
    wait_drain();
  endtask

  // Fill to the top, drop pushes at both ends, pop both ends, clear, push front
  task automatic test_fill_and_drop();
    int i;
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_item(deq_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(deq_pkg::ACT_PUSH_BACK, 32'sh8000_0000);
    send_item(deq_pkg::ACT_PUSH_FRONT, -32'sd1);
    send_item(deq_pkg::ACT_PUSH_BACK, 32'sd0);
    for (i = 4; i < DEPTH; i++) begin
      send_item(i[0] ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT, pick_value());
    end
    send_item(deq_pkg::ACT_PUSH_FRONT, pick_value());
    send_item(deq_pkg::ACT_PUSH_BACK, pick_value());
    send_item(deq_pkg::ACT_POP_FRONT, pick_value());
    send_item(deq_pkg::ACT_POP_BACK, pick_value());
    send_item(deq_pkg::ACT_CLEAR, pick_value());
    send_item(deq_pkg::ACT_PUSH_FRONT, pick_value());
    wait_drain();
  endtask

  // Hold the output off long enough that the block stalls its input
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 40; i++) begin
      send_item((i % 5 == 4) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_PUSH_BACK, pick_value());
    end
    wait_drain();
  endtask

  // Alternate fill and drain runs so the queue swings between empty and full
  task automatic test_random_phase(input int n_items, input int send_pct, input int stall_pct);
    int i;
    int roll;
    int run_left;
    bit filling;
    logic [2:0] act;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    filling  = 1'b1;
    run_left = 0;
    for (i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        filling  = 1'($urandom_range(0, 1));
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        act = deq_pkg::ACT_CLEAR;
      end else if (roll < 5) begin
        act = deq_pkg::ACT_QUERY;
      end else if (roll < 7) begin
        act = $urandom_range(0, 1) ? ACT_RSVD_6 : ACT_RSVD_7;
      end else if ((roll < 72) == filling) begin
        act = $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
      end else begin
        act = $urandom_range(0, 1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
      end
      send_item(act, pick_value());
    end
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_ends();
    test_fill_and_drop();
    test_backpressure();
    test_random_phase(420, 0, 0);
    test_random_phase(420, 54, 0);
    test_random_phase(420, 0, 54);
    test_random_phase(420, 21, 21);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #2_000_000;
    $display("double_ended_queue test failed");
    $finish;
  end

endmodule
